// ----- rtl/assert_macros.svh -----
// Assertion macros used by the top level of the reflectance scale unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a condition implies another one at the same clock edge.
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Checks that a condition is followed by another one after the delay given by dly.
`define ASSERT_DELAY(lbl, clk, rst_n, ante, dly, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##dly (cons)) \
		else $error(msg);

`endif

// ----- rtl/onrs_pkg.sv -----
// Shared constants and widths of the Oren-Nayar reflectance scale unit.
`timescale 1ns / 1ps
package onrs_pkg;
	localparam int DIR_W         = 16;
	localparam int DIR_FRAC_BITS = 14;
	localparam int OUT_FRAC_BITS = 16;
	localparam int COEF_W        = 17;
	localparam int SCALE_W       = 20;
	localparam int CFG_ADDR_W    = 1;

	// Register indexes of the configuration port.
	localparam logic [CFG_ADDR_W-1:0] REG_COEF_A = 1'b0;
	localparam logic [CFG_ADDR_W-1:0] REG_COEF_B = 1'b1;

	localparam logic [COEF_W-1:0] COEF_A_RST = 17'd65536;
	localparam logic [COEF_W-1:0] COEF_B_RST = 17'd0;

	// Bits resolved by one pipeline stage of the iterative units.
	localparam int DIV_STEP = 3;

	localparam int ST_W      = DIR_FRAC_BITS + 1;
	localparam int RAD_W     = 2 * ST_W;
	localparam int DIV_NUM_W = DIR_W + DIR_FRAC_BITS;
	localparam int CD_W      = ST_W + 1;
	localparam int M1_W      = CD_W + ST_W - DIR_FRAC_BITS;
	localparam int N_W       = 2 * DIR_FRAC_BITS + 2;
	localparam int TAN_Q_BITS = 16;
	localparam int TAN_SHIFT = TAN_Q_BITS - DIR_FRAC_BITS;
	localparam int TQ_W      = N_W + TAN_SHIFT;
	localparam int TERM_W    = COEF_W + TQ_W;
	localparam int X_W       = TERM_W + 1;
	localparam int X_LIM_BIT = 46;
	localparam int XS_LO     = 8;
	localparam int XS_W      = X_LIM_BIT - XS_LO + 1;
	localparam int PLO_W     = 20;
	localparam int PHI_W     = XS_W - PLO_W;
	localparam int KPI_W     = 25;
	localparam int SUM_W     = 64;
	localparam int SCALE_SHIFT = 50 - OUT_FRAC_BITS;
	localparam int R_W       = SUM_W - SCALE_SHIFT;

	localparam logic [ST_W-1:0]    DIR_ONE   = ST_W'(1) << DIR_FRAC_BITS;
	localparam logic [31:0]        DIR_ONE2  = 32'(1) << (2 * DIR_FRAC_BITS);
	localparam logic [X_W-1:0]     X_LIM     = X_W'(1) << X_LIM_BIT;
	localparam logic [KPI_W-1:0]   INV_PI_Q26 = 25'd21361415;
	localparam logic [SCALE_W-1:0] SCALE_MAX = '1;
endpackage

// ----- rtl/oren_nayar_reflectance_scale_unit.sv -----
// Top level of the Oren-Nayar reflectance scale unit.
// One transaction is accepted in every cycle (busy never rises), and its result
// is strobed on done once it has passed the capture and squaring stages, the
// square root, the four direction dividers, stages 3 to 7, the tangent divider
// and stages 8 to 11. The square root adds ceil(15 / DIV_STEP) stages, and the
// four direction dividers, side by side after it, add as many again: together
// 2 * ceil(15 / DIV_STEP). The tangent divider adds ceil(30 / DIV_STEP) stages.
// Eleven plain register stages make up the rest.
// Results cannot be held off, so done must be sampled when it is high.
// Write coef_a and coef_b only while no transaction is in flight.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module oren_nayar_reflectance_scale_unit #(
	parameter int DIV_STEP = onrs_pkg::DIV_STEP
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic signed [onrs_pkg::DIR_W-1:0]  in_dir_x,
	input  logic signed [onrs_pkg::DIR_W-1:0]  in_dir_y,
	input  logic signed [onrs_pkg::DIR_W-1:0]  in_dir_z,
	input  logic signed [onrs_pkg::DIR_W-1:0]  out_dir_x,
	input  logic signed [onrs_pkg::DIR_W-1:0]  out_dir_y,
	input  logic signed [onrs_pkg::DIR_W-1:0]  out_dir_z,
	input  logic                               is_reflection,
	input  logic                               cfg_we,
	input  logic [onrs_pkg::CFG_ADDR_W-1:0]    cfg_addr,
	input  logic [onrs_pkg::COEF_W-1:0]        cfg_wdata,
	output logic                               done,
	output logic [onrs_pkg::SCALE_W-1:0]       scale,
	output logic                               valid_res,
	output logic                               saturated
);
	import onrs_pkg::*;

	localparam int SQ_L = (ST_W + DIV_STEP - 1) / DIV_STEP;
	localparam int DV_L = (ST_W + DIV_STEP - 1) / DIV_STEP;
	localparam int TD_L = (N_W + DIV_STEP - 1) / DIV_STEP;
	localparam int PIPE_LAT = 11 + SQ_L + DV_L + TD_L;

	typedef struct packed {
		logic [DIR_W-1:0] xi;
		logic [DIR_W-1:0] yi;
		logic [DIR_W-1:0] xo;
		logic [DIR_W-1:0] yo;
		logic [DIR_W-1:0] azi;
		logic [DIR_W-1:0] azo;
		logic             refl;
	} dir_sb_t;

	typedef struct packed {
		logic [3:0]       neg;
		logic [3:0]       ovf;
		logic             pole_i;
		logic             pole_o;
		logic [ST_W-1:0]  st_i;
		logic [ST_W-1:0]  st_o;
		logic [DIR_W-1:0] azi;
		logic [DIR_W-1:0] azo;
		logic             refl;
	} ang_sb_t;

	typedef struct packed {
		logic nz;
		logic dz;
		logic refl;
	} tan_sb_t;

	logic [COEF_W-1:0] coef_a_q;
	logic [COEF_W-1:0] coef_b_q;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_a_q <= COEF_A_RST;
			coef_b_q <= COEF_B_RST;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_COEF_A: coef_a_q <= cfg_wdata;
				REG_COEF_B: coef_b_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Stage 1: capture the transaction.
	logic                    v_s1;
	logic signed [DIR_W-1:0] xi_s1, yi_s1, zi_s1, xo_s1, yo_s1, zo_s1;
	logic                    refl_s1;

	// Stage 2: squares of z for the polar sine.
	logic              v_s2;
	logic [31:0]       zzi_s2, zzo_s2;
	dir_sb_t           sb_s2;
	logic [RAD_W-1:0]  rad_i, rad_o;
	logic [ST_W-1:0]   st_i, st_o;

	dir_sb_t           sqd_s [SQ_L];
	logic [SQ_L-1:0]   sqv_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= start && !busy;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		xi_s1   <= in_dir_x;
		yi_s1   <= in_dir_y;
		zi_s1   <= in_dir_z;
		xo_s1   <= out_dir_x;
		yo_s1   <= out_dir_y;
		zo_s1   <= out_dir_z;
		refl_s1 <= is_reflection;
		zzi_s2  <= zi_s1 * zi_s1;
		zzo_s2  <= zo_s1 * zo_s1;
		sb_s2.xi   <= xi_s1;
		sb_s2.yi   <= yi_s1;
		sb_s2.xo   <= xo_s1;
		sb_s2.yo   <= yo_s1;
		sb_s2.azi  <= zi_s1[DIR_W-1] ? DIR_W'(-zi_s1) : zi_s1;
		sb_s2.azo  <= zo_s1[DIR_W-1] ? DIR_W'(-zo_s1) : zo_s1;
		sb_s2.refl <= refl_s1;
	end

	// 1 - z*z clamps at zero before the root.
	assign rad_i = (zzi_s2 < DIR_ONE2) ? RAD_W'(DIR_ONE2 - zzi_s2) : '0;
	assign rad_o = (zzo_s2 < DIR_ONE2) ? RAD_W'(DIR_ONE2 - zzo_s2) : '0;

	onrs_sqrt_pipe #(.RES_W(ST_W), .STEP(DIV_STEP)) u_sqrt_i (
		.clk(clk), .rad(rad_i), .root(st_i));
	onrs_sqrt_pipe #(.RES_W(ST_W), .STEP(DIV_STEP)) u_sqrt_o (
		.clk(clk), .rad(rad_o), .root(st_o));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sqv_s <= '0;
		end else begin
			sqv_s[0] <= v_s2;
			for (int k = 1; k < SQ_L; k++) sqv_s[k] <= sqv_s[k-1];
		end
	end

	always_ff @(posedge clk) begin
		sqd_s[0] <= sb_s2;
		for (int k = 1; k < SQ_L; k++) sqd_s[k] <= sqd_s[k-1];
	end

	// Azimuth cosine and sine: |c| * 2^F / sin(theta), clamped to one.
	dir_sb_t             sq_out;
	logic [DIR_W-1:0]    mag [4];
	logic [3:0]          ovf;
	logic [DIV_NUM_W-1:0] dnum [4];
	logic [ST_W-1:0]     dden [4];
	logic [ST_W-1:0]     dquo [4];
	ang_sb_t             ang_sb;
	ang_sb_t             dvd_s [DV_L];
	logic [DV_L-1:0]     dvv_s;

	assign sq_out = sqd_s[SQ_L-1];

	always_comb begin
		mag[0] = sq_out.xi[DIR_W-1] ? DIR_W'(-sq_out.xi) : sq_out.xi;
		mag[1] = sq_out.yi[DIR_W-1] ? DIR_W'(-sq_out.yi) : sq_out.yi;
		mag[2] = sq_out.xo[DIR_W-1] ? DIR_W'(-sq_out.xo) : sq_out.xo;
		mag[3] = sq_out.yo[DIR_W-1] ? DIR_W'(-sq_out.yo) : sq_out.yo;
		for (int k = 0; k < 4; k++) begin
			dden[k] = (k < 2) ? st_i : st_o;
			// A quotient of 2.0 or more is clamped anyway, so skip the division.
			ovf[k]  = {1'b0, mag[k]} >= {dden[k], 1'b0};
			dnum[k] = ovf[k] ? '0 : (DIV_NUM_W'(mag[k]) << DIR_FRAC_BITS);
			if (dden[k] == '0) dden[k] = ST_W'(1);
		end
		ang_sb.neg    = {sq_out.yo[DIR_W-1], sq_out.xo[DIR_W-1],
		                 sq_out.yi[DIR_W-1], sq_out.xi[DIR_W-1]};
		ang_sb.ovf    = ovf;
		ang_sb.pole_i = (st_i == '0);
		ang_sb.pole_o = (st_o == '0);
		ang_sb.st_i   = st_i;
		ang_sb.st_o   = st_o;
		ang_sb.azi    = sq_out.azi;
		ang_sb.azo    = sq_out.azo;
		ang_sb.refl   = sq_out.refl;
	end

	for (genvar g = 0; g < 4; g++) begin : g_adiv
		onrs_div_pipe #(
			.NUM_W(DIV_NUM_W), .DEN_W(ST_W), .Q_W(ST_W), .STEP(DIV_STEP)
		) u_div (
			.clk(clk), .num(dnum[g]), .den(dden[g]), .quo(dquo[g]));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dvv_s <= '0;
		end else begin
			dvv_s[0] <= sqv_s[SQ_L-1];
			for (int k = 1; k < DV_L; k++) dvv_s[k] <= dvv_s[k-1];
		end
	end

	always_ff @(posedge clk) begin
		dvd_s[0] <= ang_sb;
		for (int k = 1; k < DV_L; k++) dvd_s[k] <= dvd_s[k-1];
	end

	// Stage 3: signed azimuth terms.
	ang_sb_t                 dv_out;
	logic signed [DIR_W-1:0] trig [4];
	logic [ST_W-1:0]         tmag;
	logic                    v_s3;
	logic signed [DIR_W-1:0] cpi_s3, spi_s3, cpo_s3, spo_s3;
	logic [ST_W-1:0]         sti_s3, sto_s3;
	logic [DIR_W-1:0]        azi_s3, azo_s3;
	logic                    refl_s3;

	assign dv_out = dvd_s[DV_L-1];

	always_comb begin
		tmag = '0;
		for (int k = 0; k < 4; k++) begin
			tmag = (dv_out.ovf[k] || dquo[k] > DIR_ONE) ? DIR_ONE : dquo[k];
			trig[k] = dv_out.neg[k] ? -DIR_W'(tmag) : DIR_W'(tmag);
		end
		// At a pole the azimuth is taken as zero.
		if (dv_out.pole_i) begin
			trig[0] = DIR_W'(DIR_ONE);
			trig[1] = '0;
		end
		if (dv_out.pole_o) begin
			trig[2] = DIR_W'(DIR_ONE);
			trig[3] = '0;
		end
	end

	// Stages 4 to 7: cos(dphi), alpha/beta selection and the numerator.
	logic                    v_s4, v_s5, v_s6, v_s7;
	logic signed [31:0]      pc_s4, ps_s4;
	logic [ST_W-1:0]         sti_s4, sto_s4;
	logic [DIR_W-1:0]        azi_s4, azo_s4;
	logic                    refl_s4;
	logic signed [32:0]      dot;
	logic [CD_W-1:0]         cd_s5;
	logic [ST_W-1:0]         sa_s5, sb_s5, sb_s6, sb_s7_unused_free;
	logic [DIR_W-1:0]        den_s5, den_s6, den_s7;
	logic                    refl_s5, refl_s6, refl_s7;
	logic [CD_W+ST_W-1:0]    cdsa;
	logic [M1_W-1:0]         m1_s6;
	logic [M1_W+ST_W-1:0]    m1sb;
	logic [N_W-1:0]          n_s7;

	assign dot  = 33'(pc_s4) + 33'(ps_s4);
	assign cdsa = cd_s5 * sa_s5;
	assign m1sb = m1_s6 * sb_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else begin
			v_s3 <= dvv_s[DV_L-1];
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		cpi_s3  <= trig[0];
		spi_s3  <= trig[1];
		cpo_s3  <= trig[2];
		spo_s3  <= trig[3];
		sti_s3  <= dv_out.st_i;
		sto_s3  <= dv_out.st_o;
		azi_s3  <= dv_out.azi;
		azo_s3  <= dv_out.azo;
		refl_s3 <= dv_out.refl;

		pc_s4   <= cpi_s3 * cpo_s3;
		ps_s4   <= spi_s3 * spo_s3;
		sti_s4  <= sti_s3;
		sto_s4  <= sto_s3;
		azi_s4  <= azi_s3;
		azo_s4  <= azo_s3;
		refl_s4 <= refl_s3;

		cd_s5   <= (dot > 0) ? dot[DIR_FRAC_BITS+CD_W-1:DIR_FRAC_BITS] : '0;
		if (azo_s4 > azi_s4) begin
			sa_s5  <= sto_s4;
			sb_s5  <= sti_s4;
			den_s5 <= azo_s4;
		end else begin
			sa_s5  <= sti_s4;
			sb_s5  <= sto_s4;
			den_s5 <= azi_s4;
		end
		refl_s5 <= refl_s4;

		m1_s6   <= cdsa[CD_W+ST_W-1:DIR_FRAC_BITS];
		sb_s6   <= sb_s5;
		den_s6  <= den_s5;
		refl_s6 <= refl_s5;

		n_s7    <= m1sb[N_W-1:0];
		sb_s7_unused_free <= sb_s6;
		den_s7  <= den_s6;
		refl_s7 <= refl_s6;
	end

	// Tangent of beta: numerator over the larger |cos(theta)|.
	logic [DIR_W-1:0] tden;
	logic [N_W-1:0]   tquo;
	tan_sb_t          tan_sb;
	tan_sb_t          tdd_s [TD_L];
	logic [TD_L-1:0]  tdv_s;

	assign tden        = (den_s7 == '0) ? DIR_W'(1) : den_s7;
	assign tan_sb.nz   = (n_s7 != '0) && (sb_s7_unused_free != '0);
	assign tan_sb.dz   = (den_s7 == '0);
	assign tan_sb.refl = refl_s7;

	onrs_div_pipe #(
		.NUM_W(N_W), .DEN_W(DIR_W), .Q_W(N_W), .STEP(DIV_STEP)
	) u_tan_div (
		.clk(clk), .num(n_s7), .den(tden), .quo(tquo));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tdv_s <= '0;
		end else begin
			tdv_s[0] <= v_s7;
			for (int k = 1; k < TD_L; k++) tdv_s[k] <= tdv_s[k-1];
		end
	end

	always_ff @(posedge clk) begin
		tdd_s[0] <= tan_sb;
		for (int k = 1; k < TD_L; k++) tdd_s[k] <= tdd_s[k-1];
	end

	// Stages 8 to 11: B term, sum with A, scaling by 1/pi and saturation.
	tan_sb_t             td_out;
	logic                bterm;
	logic [TQ_W-1:0]     tq;
	logic                v_s8, v_s9, v_s10, v_s11;
	logic [TERM_W-1:0]   term_s8;
	logic                sat_s8, sat_s9, sat_s10;
	logic                refl_s8, refl_s9, refl_s10;
	logic [X_W-1:0]      xsum;
	logic [XS_W-1:0]     xs_s9;
	logic [PLO_W+KPI_W-1:0] plo_s10;
	logic [PHI_W+KPI_W-1:0] phi_s10;
	logic [SUM_W-1:0]    psum;
	logic [R_W-1:0]      rval;
	logic                sat_f;

	assign td_out = tdd_s[TD_L-1];
	assign bterm  = (coef_b_q != '0) && td_out.nz;
	assign tq     = TQ_W'(tquo) << TAN_SHIFT;
	assign xsum   = X_W'({coef_a_q, 16'b0}) + X_W'(term_s8);
	assign psum   = SUM_W'(plo_s10) + (SUM_W'(phi_s10) << PLO_W);
	assign rval   = psum[SUM_W-1:SCALE_SHIFT];
	assign sat_f  = sat_s10 || (rval > R_W'(SCALE_MAX));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s8  <= 1'b0;
			v_s9  <= 1'b0;
			v_s10 <= 1'b0;
			v_s11 <= 1'b0;
		end else begin
			v_s8  <= tdv_s[TD_L-1];
			v_s9  <= v_s8;
			v_s10 <= v_s9;
			v_s11 <= v_s10;
		end
	end

	always_ff @(posedge clk) begin
		sat_s8  <= bterm && td_out.dz;
		term_s8 <= (bterm && !td_out.dz) ? coef_b_q * tq : '0;
		refl_s8 <= td_out.refl;

		sat_s9  <= sat_s8 || (xsum > X_LIM);
		xs_s9   <= xsum[X_LIM_BIT:XS_LO];
		refl_s9 <= refl_s8;

		plo_s10  <= xs_s9[PLO_W-1:0] * INV_PI_Q26;
		phi_s10  <= xs_s9[XS_W-1:PLO_W] * INV_PI_Q26;
		sat_s10  <= sat_s9;
		refl_s10 <= refl_s9;

		valid_res <= refl_s10;
		saturated <= refl_s10 && sat_f;
		if (!refl_s10) scale <= '0;
		else if (sat_f) scale <= SCALE_MAX;
		else scale <= rval[SCALE_W-1:0];
	end

	assign done = v_s11;

	`ASSERT_DELAY(a_latency, clk, arst_n, start && !busy, PIPE_LAT, done,
		"result strobe missing after a transaction")
	`ASSERT_IMPLY(a_trans_zero, clk, arst_n, done && !valid_res,
		scale == '0 && !saturated, "transmission result is not zero")
	`ASSERT_IMPLY(a_sat_max, clk, arst_n, done && saturated,
		scale == SCALE_MAX, "saturated result below the maximum")
endmodule

// ----- rtl/onrs_div_pipe.sv -----
// Pipelined unsigned restoring divider, STEP quotient bits per stage.
`timescale 1ns / 1ps
module onrs_div_pipe #(
	parameter int NUM_W = 30,
	parameter int DEN_W = 15,
	parameter int Q_W   = 15,
	parameter int STEP  = 3
) (
	input  logic             clk,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic [Q_W-1:0]   quo
);
	localparam int NS = (Q_W + STEP - 1) / STEP;
	localparam int QP = NS * STEP;
	localparam int NW = QP + DEN_W;

	// The caller keeps num below den * 2^Q_W, so the quotient fits Q_W bits.
	logic [NW-1:0]    numx;
	logic [DEN_W-1:0] rem_s [NS];
	logic [QP-1:0]    low_s [NS];
	logic [QP-1:0]    quo_s [NS];
	logic [DEN_W-1:0] den_s [NS];

	assign numx = NW'(num);

	for (genvar k = 0; k < NS; k++) begin : g_stage
		logic [DEN_W-1:0] rem_in;
		logic [QP-1:0]    low_in;
		logic [QP-1:0]    quo_in;
		logic [DEN_W-1:0] den_in;
		logic [DEN_W-1:0] rem_n;
		logic [QP-1:0]    low_n;
		logic [QP-1:0]    quo_n;
		logic [DEN_W:0]   trial;

		if (k == 0) begin : g_first
			assign rem_in = numx[NW-1:QP];
			assign low_in = numx[QP-1:0];
			assign quo_in = '0;
			assign den_in = den;
		end else begin : g_next
			assign rem_in = rem_s[k-1];
			assign low_in = low_s[k-1];
			assign quo_in = quo_s[k-1];
			assign den_in = den_s[k-1];
		end

		always_comb begin
			rem_n = rem_in;
			low_n = low_in;
			quo_n = quo_in;
			trial = '0;
			for (int j = 0; j < STEP; j++) begin
				trial = {rem_n, low_n[QP-1]};
				low_n = low_n << 1;
				if (trial >= {1'b0, den_in}) begin
					trial = trial - {1'b0, den_in};
					quo_n = {quo_n[QP-2:0], 1'b1};
				end else begin
					quo_n = {quo_n[QP-2:0], 1'b0};
				end
				rem_n = trial[DEN_W-1:0];
			end
		end

		always_ff @(posedge clk) begin
			rem_s[k] <= rem_n;
			low_s[k] <= low_n;
			quo_s[k] <= quo_n;
			den_s[k] <= den_in;
		end
	end

	assign quo = quo_s[NS-1][Q_W-1:0];
endmodule

// ----- rtl/onrs_sqrt_pipe.sv -----
// Pipelined integer square root, STEP result bits per stage.
`timescale 1ns / 1ps
module onrs_sqrt_pipe #(
	parameter int RES_W = 15,
	parameter int STEP  = 3
) (
	input  logic               clk,
	input  logic [2*RES_W-1:0] rad,
	output logic [RES_W-1:0]   root
);
	localparam int NS    = (RES_W + STEP - 1) / STEP;
	localparam int RP    = NS * STEP;
	localparam int REM_W = RP + 3;

	logic [2*RP-1:0]  radx;
	logic [REM_W-1:0] rem_s  [NS];
	logic [2*RP-1:0]  low_s  [NS];
	logic [RP-1:0]    root_s [NS];

	assign radx = (2*RP)'(rad);

	for (genvar k = 0; k < NS; k++) begin : g_stage
		logic [REM_W-1:0] rem_in;
		logic [2*RP-1:0]  low_in;
		logic [RP-1:0]    root_in;
		logic [REM_W-1:0] rem_n;
		logic [2*RP-1:0]  low_n;
		logic [RP-1:0]    root_n;
		logic [REM_W-1:0] trial;
		logic [REM_W-1:0] cand;

		if (k == 0) begin : g_first
			assign rem_in  = '0;
			assign low_in  = radx;
			assign root_in = '0;
		end else begin : g_next
			assign rem_in  = rem_s[k-1];
			assign low_in  = low_s[k-1];
			assign root_in = root_s[k-1];
		end

		// Digit-by-digit method: two radicand bits in, one root bit out.
		always_comb begin
			rem_n  = rem_in;
			low_n  = low_in;
			root_n = root_in;
			trial  = '0;
			cand   = '0;
			for (int j = 0; j < STEP; j++) begin
				trial = {rem_n[REM_W-3:0], low_n[2*RP-1:2*RP-2]};
				low_n = low_n << 2;
				cand  = REM_W'({root_n, 2'b01});
				if (trial >= cand) begin
					rem_n  = trial - cand;
					root_n = {root_n[RP-2:0], 1'b1};
				end else begin
					rem_n  = trial;
					root_n = {root_n[RP-2:0], 1'b0};
				end
			end
		end

		always_ff @(posedge clk) begin
			rem_s[k]  <= rem_n;
			low_s[k]  <= low_n;
			root_s[k] <= root_n;
		end
	end

	assign root = root_s[NS-1][RES_W-1:0];
endmodule
